FILE: hdl/sdt_pkg.sv
// sdt_pkg: shared types and constants for the seen device table
// holds table geometry, entry layout, item kinds and controller states
// no dependencies
package sdt_pkg;

   localparam int ENTRIES = 32;
   localparam int IDX_W   = $clog2(ENTRIES);
   localparam int CNT_W   = 6;
   localparam int ADDR_W  = 48;
   localparam int TYPE_W  = 2;
   localparam int RSSI_W  = 8;
   localparam int TIME_W  = 32;
   localparam int RIDX_W  = 6;

   typedef logic [IDX_W-1:0] idx_type;
   typedef logic [IDX_W:0]   scan_type;
   typedef logic [CNT_W-1:0] cnt_type;

   localparam scan_type SCAN_END = scan_type'(ENTRIES);

   typedef struct packed {
      logic        [ADDR_W-1:0] address;
      logic        [TYPE_W-1:0] atype;
      logic signed [RSSI_W-1:0] rssi;
      logic        [TIME_W-1:0] last_seen;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef enum logic [1:0] {
      KIND_SIGHT = 2'd0,
      KIND_PRUNE = 2'd1,
      KIND_READ  = 2'd2,
      KIND_NONE  = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } state_type;

endpackage

FILE: hdl/sdt_ram.sv
// sdt_ram: generic single-write, single-read synchronous ram
// read data is registered
// no dependencies
module sdt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hdl/seen_device_table_lru.sv
// seen_device_table_lru: table of recently seen devices keyed by 48-bit address
// entry data lives in one sdt_ram; valid flags and the valid count are flip-flops
// depends on sdt_pkg and sdt_ram
//
// Usage: items enter on the req_ channel (valid/ready). kind 0 records a
// sighting (matching slot, else lowest free slot, else the oldest slot),
// kind 1 prunes entries whose wrapping age exceeds req_age_limit, kind 2
// reads the n-th valid entry in slot order, kind 3 only reports the count.
// Every item gives exactly one result on the rsp_ channel (valid/ready).
// Each item scans all 32 slots through the single ram read port, one slot
// per cycle: the item is taken, each slot is read in turn, the registered
// read data is checked, then a finish step writes the chosen slot for a
// sighting and loads the result register. The result becomes valid and
// req_ready returns in the same cycle, so a new item is taken only once the
// last one has passed its finish step.
// The result register holds a finished result while the receiver stalls;
// the next item may be taken meanwhile and waits in its finish step until
// the register frees. Reset (synchronous, active high) clears all valid
// flags and the count at once; stored entry data needs no clearing.
module seen_device_table_lru (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic [1:0]                             req_kind,
   input  logic [sdt_pkg::ADDR_W-1:0]             req_device_address,
   input  logic [sdt_pkg::TYPE_W-1:0]             req_address_type,
   input  logic signed [sdt_pkg::RSSI_W-1:0]      req_signal_strength,
   input  logic [sdt_pkg::TIME_W-1:0]             req_now_time,
   input  logic [sdt_pkg::TIME_W-1:0]             req_age_limit,
   input  logic [sdt_pkg::RIDX_W-1:0]             req_read_index,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic                                   rsp_found,
   output logic [sdt_pkg::IDX_W-1:0]              rsp_slot_index,
   output logic [sdt_pkg::ADDR_W-1:0]             rsp_entry_address,
   output logic [sdt_pkg::TYPE_W-1:0]             rsp_entry_addr_type,
   output logic signed [sdt_pkg::RSSI_W-1:0]      rsp_entry_rssi,
   output logic [sdt_pkg::TIME_W-1:0]             rsp_entry_last_seen,
   output logic [sdt_pkg::CNT_W-1:0]              rsp_removed_count,
   output logic [sdt_pkg::CNT_W-1:0]              rsp_valid_count
);

   sdt_pkg::state_type state_ff, state_in;

   // control state
   logic [sdt_pkg::ENTRIES-1:0] valid_ff;
   sdt_pkg::cnt_type            count_ff;
   sdt_pkg::scan_type           scan_ff;
   logic                        chk_vld_ff;
   sdt_pkg::idx_type            chk_idx_ff;
   logic                        rsp_valid_ff;

   // latched item
   sdt_pkg::kind_type                kind_ff;
   logic [sdt_pkg::ADDR_W-1:0]       addr_ff;
   logic [sdt_pkg::TYPE_W-1:0]       atype_ff;
   logic signed [sdt_pkg::RSSI_W-1:0] rssi_ff;
   logic [sdt_pkg::TIME_W-1:0]       now_ff;
   logic [sdt_pkg::TIME_W-1:0]       limit_ff;
   logic [sdt_pkg::RIDX_W-1:0]       ridx_ff;

   // scan results
   logic                       match_ff;
   sdt_pkg::idx_type           match_slot_ff;
   logic                       free_ff;
   sdt_pkg::idx_type           open_slot_ff;
   logic                       old_ff;
   sdt_pkg::idx_type           old_slot_ff;
   logic [sdt_pkg::TIME_W-1:0] old_time_ff;
   sdt_pkg::cnt_type           seen_ff;
   sdt_pkg::cnt_type           removed_ff;
   logic                       hit_ff;
   sdt_pkg::idx_type           hit_slot_ff;
   sdt_pkg::entry_type         hit_entry_ff;

   // result register
   logic                       res_found_ff;
   sdt_pkg::idx_type           res_slot_ff;
   sdt_pkg::entry_type         res_entry_ff;
   sdt_pkg::cnt_type           res_removed_ff;
   sdt_pkg::cnt_type           res_count_ff;

   // combinational
   logic               take;
   logic               scanning;
   logic               load;
   logic               mem_we;
   sdt_pkg::idx_type   fin_slot;
   sdt_pkg::cnt_type   cnt_after;
   sdt_pkg::entry_type rd_entry;
   logic [sdt_pkg::ENTRY_W-1:0] rd_data;
   logic               chk_valid;
   logic [sdt_pkg::TIME_W-1:0] age;
   sdt_pkg::entry_type wr_entry;

   sdt_ram #(
      .WIDTH (sdt_pkg::ENTRY_W),
      .DEPTH (sdt_pkg::ENTRIES)
   ) u_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (fin_slot),
      .wr_data (wr_entry),
      .rd_en   (scanning),
      .rd_addr (scan_ff[sdt_pkg::IDX_W-1:0]),
      .rd_data (rd_data)
   );

   assign rd_entry  = sdt_pkg::entry_type'(rd_data);
   assign chk_valid = valid_ff[chk_idx_ff];
   assign age       = now_ff - rd_entry.last_seen;

   assign wr_entry.address   = addr_ff;
   assign wr_entry.atype     = atype_ff;
   assign wr_entry.rssi      = rssi_ff;
   assign wr_entry.last_seen = now_ff;

   // slot for a sighting: match, then lowest free, then oldest
   always_comb begin
      priority if (match_ff) begin
         fin_slot = match_slot_ff;
      end else if (free_ff) begin
         fin_slot = open_slot_ff;
      end else begin
         fin_slot = old_slot_ff;
      end
   end

   always_comb begin
      if (kind_ff == sdt_pkg::KIND_SIGHT && !valid_ff[fin_slot]) begin
         cnt_after = count_ff + sdt_pkg::cnt_type'(1);
      end else begin
         cnt_after = count_ff;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         sdt_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = sdt_pkg::ST_SCAN;
            end
         end
         sdt_pkg::ST_SCAN: begin
            if (scan_ff == sdt_pkg::SCAN_END) begin
               state_in = sdt_pkg::ST_FINISH;
            end
         end
         sdt_pkg::ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               state_in = sdt_pkg::ST_IDLE;
            end
         end
         default: state_in = sdt_pkg::ST_IDLE;
      endcase
   end

   // outputs of the controller
   always_comb begin
      req_ready = 1'b0;
      scanning  = 1'b0;
      load      = 1'b0;
      unique case (state_ff)
         sdt_pkg::ST_IDLE:   req_ready = 1'b1;
         sdt_pkg::ST_SCAN:   scanning  = (scan_ff != sdt_pkg::SCAN_END);
         sdt_pkg::ST_FINISH: load      = !rsp_valid_ff || rsp_ready;
         default: ;
      endcase
      take   = req_ready && req_valid;
      mem_we = load && (kind_ff == sdt_pkg::KIND_SIGHT);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sdt_pkg::ST_IDLE;
         valid_ff     <= '0;
         count_ff     <= '0;
         scan_ff      <= '0;
         chk_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         chk_vld_ff <= scanning;
         if (take) begin
            scan_ff <= '0;
         end else if (scanning) begin
            scan_ff <= scan_ff + sdt_pkg::scan_type'(1);
         end
         // prune clears flags as the scan passes them
         if (chk_vld_ff && kind_ff == sdt_pkg::KIND_PRUNE && chk_valid
             && age > limit_ff) begin
            valid_ff[chk_idx_ff] <= 1'b0;
            count_ff             <= count_ff - sdt_pkg::cnt_type'(1);
         end
         if (load) begin
            count_ff <= cnt_after;
            if (kind_ff == sdt_pkg::KIND_SIGHT) begin
               valid_ff[fin_slot] <= 1'b1;
            end
         end
         if (load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      chk_idx_ff <= scan_ff[sdt_pkg::IDX_W-1:0];
      if (take) begin
         kind_ff    <= sdt_pkg::kind_type'(req_kind);
         addr_ff    <= req_device_address;
         atype_ff   <= req_address_type;
         rssi_ff    <= req_signal_strength;
         now_ff     <= req_now_time;
         limit_ff   <= req_age_limit;
         ridx_ff    <= req_read_index;
         match_ff   <= 1'b0;
         free_ff    <= 1'b0;
         old_ff     <= 1'b0;
         seen_ff    <= '0;
         removed_ff <= '0;
         hit_ff     <= 1'b0;
      end else if (chk_vld_ff) begin
         unique case (kind_ff)
            sdt_pkg::KIND_SIGHT: begin
               if (chk_valid) begin
                  if (rd_entry.address == addr_ff && !match_ff) begin
                     match_ff      <= 1'b1;
                     match_slot_ff <= chk_idx_ff;
                  end
                  if (!old_ff || rd_entry.last_seen < old_time_ff) begin
                     old_ff      <= 1'b1;
                     old_time_ff <= rd_entry.last_seen;
                     old_slot_ff <= chk_idx_ff;
                  end
               end else if (!free_ff) begin
                  free_ff      <= 1'b1;
                  open_slot_ff <= chk_idx_ff;
               end
            end
            sdt_pkg::KIND_PRUNE: begin
               if (chk_valid && age > limit_ff) begin
                  removed_ff <= removed_ff + sdt_pkg::cnt_type'(1);
               end
            end
            sdt_pkg::KIND_READ: begin
               if (chk_valid) begin
                  if (seen_ff == ridx_ff && !hit_ff) begin
                     hit_ff       <= 1'b1;
                     hit_slot_ff  <= chk_idx_ff;
                     hit_entry_ff <= rd_entry;
                  end
                  seen_ff <= seen_ff + sdt_pkg::cnt_type'(1);
               end
            end
            sdt_pkg::KIND_NONE: ;
            default: ;
         endcase
      end
      if (load) begin
         res_count_ff <= cnt_after;
         res_found_ff <= 1'b0;
         res_slot_ff  <= '0;
         res_entry_ff <= '0;
         res_removed_ff <= '0;
         unique case (kind_ff)
            sdt_pkg::KIND_SIGHT: begin
               res_found_ff <= 1'b1;
               res_slot_ff  <= fin_slot;
            end
            sdt_pkg::KIND_PRUNE: res_removed_ff <= removed_ff;
            sdt_pkg::KIND_READ: begin
               if (hit_ff) begin
                  res_found_ff <= 1'b1;
                  res_slot_ff  <= hit_slot_ff;
                  res_entry_ff <= hit_entry_ff;
               end
            end
            sdt_pkg::KIND_NONE: ;
            default: ;
         endcase
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_found           = res_found_ff;
   assign rsp_slot_index      = res_slot_ff;
   assign rsp_entry_address   = res_entry_ff.address;
   assign rsp_entry_addr_type = res_entry_ff.atype;
   assign rsp_entry_rssi      = res_entry_ff.rssi;
   assign rsp_entry_last_seen = res_entry_ff.last_seen;
   assign rsp_removed_count   = res_removed_ff;
   assign rsp_valid_count     = res_count_ff;

endmodule
